@@ hw/rtl/pfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types, codes and default sizes of the power-of-two free-list allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

   // fixed field widths
   localparam int SIZE_W   = 16;
   localparam int ADDR_W   = 32;
   localparam int BYTES_W  = 15;
   localparam int STATUS_W = 2;
   localparam int CLASS_W  = 4;

   // default sizing handed to the top level
   localparam int NUM_CLASSES_DEF     = 12;
   localparam int MIN_BLOCK_BYTES_DEF = 8;
   localparam int HEAP_GRANULES_DEF   = 32768;
   localparam int HEADER_BYTES_DEF    = 4;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEMORY = 2'd2;

   // classified request, front to back
   typedef struct packed {
      logic               op;
      logic               too_large;
      logic [CLASS_W-1:0] cls;
      logic [ADDR_W-1:0]  offset;
   } pfa_cmd_type;

endpackage

@@ hw/rtl/pfa_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa channel interfaces
// request, response and register write channels with valid/ready
// ----------------------------------------------------------------------------
interface pfa_req_if import pfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [SIZE_W-1:0] request_size;
   logic [ADDR_W-1:0] block_address;

   modport source (output valid, operation, request_size, block_address, input ready);
   modport sink   (input valid, operation, request_size, block_address, output ready);
endinterface

interface pfa_rsp_if import pfa_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   result_address;
   logic [BYTES_W-1:0]  block_bytes;
   logic [STATUS_W-1:0] status;

   modport source (output valid, result_address, block_bytes, status, input ready);
   modport sink   (input valid, result_address, block_bytes, status, output ready);
endinterface

interface pfa_csr_if import pfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] heap_base;

   modport source (output valid, heap_base, input ready);
   modport sink   (input valid, heap_base, output ready);
endinterface

@@ hw/rtl/pfa_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_front
// takes request beats, picks the size class or the heap offset to free
// ----------------------------------------------------------------------------
module pfa_front import pfa_pkg::*; #(
   parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
   parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
   parameter int HEADER_BYTES    = HEADER_BYTES_DEF
) (
   pfa_req_if.sink           req_if,
   input  logic [ADDR_W-1:0] heap_base,
   output logic              push_valid,
   input  logic              push_ready,
   output pfa_cmd_type       push_cmd
);

   localparam logic [ADDR_W-1:0] MAX_BLOCK = ADDR_W'(MIN_BLOCK_BYTES) << (NUM_CLASSES - 1);

   logic [ADDR_W-1:0]  need;
   logic [CLASS_W-1:0] cls;

   assign need = ADDR_W'(req_if.request_size) + ADDR_W'(HEADER_BYTES);

   // smallest class that holds the request plus header
   always_comb begin
      cls = CLASS_W'(NUM_CLASSES - 1);
      for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
         if (need <= (ADDR_W'(MIN_BLOCK_BYTES) << c)) begin
            cls = CLASS_W'(c);
         end
      end
   end

   assign push_valid       = req_if.valid;
   assign req_if.ready     = push_ready;
   assign push_cmd.op        = req_if.operation;
   assign push_cmd.too_large = (need > MAX_BLOCK);
   assign push_cmd.cls       = cls;
   assign push_cmd.offset    = req_if.block_address - heap_base - ADDR_W'(HEADER_BYTES);

endmodule

@@ hw/rtl/pfa_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module pfa_queue import pfa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  pfa_cmd_type push_cmd,
   output logic        pop_valid,
   input  logic        pop_ready,
   output pfa_cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   pfa_cmd_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hw/rtl/pfa_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa_back
// executes commands on the class lists, bump pointer and block memories
// ----------------------------------------------------------------------------
module pfa_back import pfa_pkg::*; #(
   parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
   parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
   parameter int HEAP_GRANULES   = HEAP_GRANULES_DEF,
   parameter int HEADER_BYTES    = HEADER_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ADDR_W-1:0] heap_base,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  pfa_cmd_type       pop_cmd,
   pfa_rsp_if.source         rsp_if
);

   localparam int GRAN_W  = $clog2(HEAP_GRANULES);
   localparam int HEAD_W  = $clog2(HEAP_GRANULES + 1);
   localparam int LOG_MIN = $clog2(MIN_BLOCK_BYTES);
   localparam int IDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int CNT_W   = (HEAD_W > 16) ? HEAD_W : 16;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_POP  = 2'd1;
   localparam logic [1:0] ST_FREE = 2'd2;

   logic [1:0]          state_ff, state_in;
   pfa_cmd_type         cmd_ff, cmd_in;
   logic [HEAD_W-1:0]   head_ff [NUM_CLASSES];
   logic [HEAD_W-1:0]   bump_ff, bump_in;

   logic                head_we;
   logic [IDX_W-1:0]    head_wa;
   logic [HEAD_W-1:0]   head_wd;

   logic [HEAD_W-1:0]   link_mem [HEAP_GRANULES];
   logic                link_we, link_re;
   logic [GRAN_W-1:0]   link_wa, link_ra;
   logic [HEAD_W-1:0]   link_wd, link_rd_ff;

   logic [CLASS_W-1:0]  class_mem [HEAP_GRANULES];
   logic                class_we, class_re;
   logic [GRAN_W-1:0]   class_wa, class_ra;
   logic [CLASS_W-1:0]  class_wd, class_rd_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [BYTES_W-1:0]  rsp_bytes_ff, rsp_bytes_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                emit;

   pfa_cmd_type         cur;
   logic                out_free;
   logic [IDX_W-1:0]    cur_idx, free_idx;
   logic [HEAD_W-1:0]   head_sel;
   logic [GRAN_W-1:0]   pop_gran, free_gran;
   logic [CNT_W-1:0]    cls_grans, room;

   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign cur       = (state_ff == ST_IDLE) ? pop_cmd : cmd_ff;
   assign cur_idx   = cur.cls[IDX_W-1:0];
   assign head_sel  = head_ff[cur_idx];
   assign pop_gran  = GRAN_W'(head_sel - 1'b1);
   assign free_gran = cur.offset[LOG_MIN +: GRAN_W];
   assign free_idx  = class_rd_ff[IDX_W-1:0];
   assign cls_grans = CNT_W'(1) << cur.cls;
   assign room      = CNT_W'(HEAP_GRANULES) - CNT_W'(bump_ff);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      bump_in       = bump_ff;
      pop_ready     = 1'b0;
      head_we       = 1'b0;
      head_wa       = cur_idx;
      head_wd       = '0;
      link_we       = 1'b0;
      link_wa       = free_gran;
      link_wd       = '0;
      link_re       = 1'b0;
      link_ra       = pop_gran;
      class_we      = 1'b0;
      class_wa      = pop_gran;
      class_wd      = cur.cls;
      class_re      = 1'b0;
      class_ra      = free_gran;
      emit          = 1'b0;
      rsp_addr_in   = '0;
      rsp_bytes_in  = '0;
      rsp_status_in = STATUS_OK;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready = 1'b1;
               cmd_in    = pop_cmd;
               if (pop_cmd.op == OP_FREE) begin
                  class_re = 1'b1;
                  state_in = ST_FREE;
               end else if (pop_cmd.too_large) begin
                  emit          = 1'b1;
                  rsp_status_in = STATUS_TOO_LARGE;
               end else if (head_sel != '0) begin
                  link_re  = 1'b1;
                  state_in = ST_POP;
               end else if (cls_grans > room) begin
                  emit          = 1'b1;
                  rsp_status_in = STATUS_NO_MEMORY;
               end else begin
                  // carve from the bump pointer
                  class_we     = 1'b1;
                  class_wa     = bump_ff[GRAN_W-1:0];
                  bump_in      = bump_ff + HEAD_W'(cls_grans);
                  emit         = 1'b1;
                  rsp_addr_in  = heap_base + (ADDR_W'(bump_ff) << LOG_MIN)
                                 + ADDR_W'(HEADER_BYTES);
                  rsp_bytes_in = BYTES_W'(ADDR_W'(MIN_BLOCK_BYTES) << cur.cls);
               end
            end
         end
         ST_POP: begin
            if (out_free) begin
               head_we      = 1'b1;
               head_wd      = link_rd_ff;
               class_we     = 1'b1;
               emit         = 1'b1;
               rsp_addr_in  = heap_base + (ADDR_W'(pop_gran) << LOG_MIN)
                              + ADDR_W'(HEADER_BYTES);
               rsp_bytes_in = BYTES_W'(ADDR_W'(MIN_BLOCK_BYTES) << cur.cls);
               state_in     = ST_IDLE;
            end
         end
         ST_FREE: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (32'(class_rd_ff) >= NUM_CLASSES) begin
                  rsp_status_in = STATUS_TOO_LARGE;
               end else begin
                  link_we      = 1'b1;
                  link_wd      = head_ff[free_idx];
                  head_we      = 1'b1;
                  head_wa      = free_idx;
                  head_wd      = HEAD_W'(free_gran) + 1'b1;
                  rsp_bytes_in = BYTES_W'(ADDR_W'(MIN_BLOCK_BYTES) << class_rd_ff);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bump_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CLASSES; i++) begin
            head_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         bump_ff      <= bump_in;
         rsp_valid_ff <= rsp_valid_in;
         if (head_we) begin
            head_ff[head_wa] <= head_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      if (emit) begin
         rsp_addr_ff   <= rsp_addr_in;
         rsp_bytes_ff  <= rsp_bytes_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   // free-list links
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      if (link_re) begin
         link_rd_ff <= link_mem[link_ra];
      end
   end

   // class of each carved block
   always_ff @(posedge clock) begin
      if (class_we) begin
         class_mem[class_wa] <= class_wd;
      end
      if (class_re) begin
         class_rd_ff <= class_mem[class_ra];
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.result_address = rsp_addr_ff;
   assign rsp_if.block_bytes    = rsp_bytes_ff;
   assign rsp_if.status         = rsp_status_ff;

endmodule

@@ hw/rtl/power_of_two_free_list_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_of_two_free_list_allocator
// segregated power-of-two free-list allocator with bump-pointer fallback
// ----------------------------------------------------------------------------
//  channel   dir   payload                                   beat
//  req_if    in    operation, request_size, block_address    one request
//  rsp_if    out   result_address, block_bytes, status       one result
//  csr_if    in    heap_base                                 one register write
//
//  an allocate that pops a free list and every free read the link or class memory
//  from the idle state and write back the list head in ST_POP or ST_FREE; an
//  allocate from the bump pointer or a rejected one is answered from the idle state
//  a two-entry command queue sits between the classifier and the back end
//  reset is synchronous, clears list heads, bump pointer and handshake state;
//  block memories need no clearing pass
//  the back end holds a finished result while rsp_if is stalled, and the queue
//  keeps taking requests until it is full
// ----------------------------------------------------------------------------
module power_of_two_free_list_allocator import pfa_pkg::*; #(
   parameter int NUM_CLASSES     = NUM_CLASSES_DEF,
   parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
   // power of two: the granule index of a freed address wraps by masking
   parameter int HEAP_GRANULES   = HEAP_GRANULES_DEF,
   parameter int HEADER_BYTES    = HEADER_BYTES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   pfa_req_if.sink   req_if,
   pfa_rsp_if.source rsp_if,
   pfa_csr_if.sink   csr_if
);

   logic [ADDR_W-1:0] heap_base_ff, heap_base_in;
   logic              push_valid, push_ready;
   pfa_cmd_type       push_cmd;
   logic              pop_valid, pop_ready;
   pfa_cmd_type       pop_cmd;

   // register writes are taken at any time
   assign csr_if.ready = 1'b1;
   assign heap_base_in = (csr_if.valid) ? csr_if.heap_base : heap_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_base_ff <= '0;
      end else begin
         heap_base_ff <= heap_base_in;
      end
   end

   // classify: size class for allocate, heap offset for free
   pfa_front #(
      .NUM_CLASSES     (NUM_CLASSES),
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
      .HEADER_BYTES    (HEADER_BYTES)
   ) u_front (
      .req_if     (req_if),
      .heap_base  (heap_base_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   pfa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // execute against lists, bump pointer and block memories
   pfa_back #(
      .NUM_CLASSES     (NUM_CLASSES),
      .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
      .HEAP_GRANULES   (HEAP_GRANULES),
      .HEADER_BYTES    (HEADER_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .heap_base (heap_base_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .rsp_if    (rsp_if)
   );

endmodule

@@ sim/power_of_two_free_list_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_of_two_free_list_allocator_tb
// The testbench sends allocate and free requests and checks each result beat
// against a predictor that keeps its own list heads, bump pointer and block
// memories. Directed tests cover the size-class edges, LIFO reuse, a double
// free and heap exhaustion. Random phases run under several heap bases with
// random gaps on both channels, but for one phase that runs with no gaps.
// ----------------------------------------------------------------------------
module power_of_two_free_list_allocator_tb;
   import pfa_pkg::*;

   // sizing as built into the block
   localparam int NCLS          = NUM_CLASSES_DEF;
   localparam int MIN_BLK       = MIN_BLOCK_BYTES_DEF;
   localparam int GRANULES      = HEAP_GRANULES_DEF;
   localparam int HDR           = HEADER_BYTES_DEF;
   localparam int MAX_BLOCK     = MIN_BLK << (NCLS - 1);
   localparam int HEAP_BYTES    = GRANULES * MIN_BLK;
   localparam int SETTLE_CYCLES = 8;

   // one expected result beat; op is kept for the tally only
   typedef struct {
      logic                op;
      logic [ADDR_W-1:0]   address;
      logic [BYTES_W-1:0]  bytes;
      logic [STATUS_W-1:0] status;
   } grant_type;

   logic clock = 1'b0;
   logic reset;

   pfa_req_if req_bus ();
   pfa_rsp_if rsp_bus ();
   pfa_csr_if csr_bus ();

   power_of_two_free_list_allocator u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #10 clock = ~clock;

   // allocator state as the predictor sees it
   logic [ADDR_W-1:0] model_base;
   logic [15:0]       class_heads [NCLS];
   logic [18:0]       bump_ptr;
   logic [15:0]       link_mem    [GRANULES];
   logic [3:0]        class_mem   [GRANULES];

   grant_type pending_grants [$];
   int        live_blocks    [$];   // granules of blocks handed out and not yet freed

   bit gapless = 1'b0;           // no idling on either side while set
   int fail_count  = 0;
   int alloc_count = 0;
   int free_count  = 0;
   int large_count = 0;
   int full_count  = 0;
   int base_writes = 0;

   // ---------------------------------------------------------------------------
   // predictor: advances the allocator state by one request
   // ---------------------------------------------------------------------------
   function automatic grant_type compute_grant(input logic op, input logic [SIZE_W-1:0] size,
                                               input logic [ADDR_W-1:0] addr);
      grant_type   g;
      logic [31:0] need;
      logic [31:0] bytes;
      logic [31:0] offs;
      int          cls;
      int          gran;
      g.op      = op;
      g.address = '0;
      g.bytes   = '0;
      g.status  = STATUS_OK;
      if (op == OP_ALLOC) begin
         need = size + HDR;
         if (need > MAX_BLOCK) begin
            g.status = STATUS_TOO_LARGE;
            return g;
         end
         // smallest power-of-two class that holds request plus header
         cls   = 0;
         bytes = MIN_BLK;
         while (bytes < need && cls < NCLS - 1) begin
            bytes = bytes << 1;
            cls++;
         end
         if (class_heads[cls] != 0) begin
            // pop the LIFO list of this class
            gran             = (class_heads[cls] - 1) % GRANULES;
            class_heads[cls] = link_mem[gran];
            offs             = gran * MIN_BLK;
         end else begin
            // carve from the bump pointer unless it would run past the heap end
            if (bump_ptr > HEAP_BYTES || bytes > HEAP_BYTES - bump_ptr) begin
               g.status = STATUS_NO_MEMORY;
               return g;
            end
            offs     = 32'(bump_ptr);
            bump_ptr = 19'(bump_ptr + bytes);
            gran     = (offs / MIN_BLK) % GRANULES;
         end
         class_mem[gran] = CLASS_W'(cls);
         g.address       = model_base + offs + HDR;
         g.bytes         = bytes[BYTES_W-1:0];
      end else begin
         // low bits below a granule are dropped, the granule index wraps
         offs = addr - model_base - HDR;
         gran = (offs / MIN_BLK) % GRANULES;
         cls  = int'(class_mem[gran]);
         if (cls >= NCLS) begin
            g.status = STATUS_TOO_LARGE;
            return g;
         end
         link_mem[gran]   = class_heads[cls];
         class_heads[cls] = 16'(gran + 1);
         g.bytes          = BYTES_W'(MIN_BLK << cls);
      end
      return g;
   endfunction

   // user address of a granule, with junk in the low bits and a heap-size wrap
   function automatic logic [ADDR_W-1:0] user_address(input int gran);
      logic [ADDR_W-1:0] wrap;
      wrap = $urandom * HEAP_BYTES;
      return model_base + HDR + gran * MIN_BLK + $urandom_range(MIN_BLK - 1) + wrap;
   endfunction

   // ---------------------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------------------
   task automatic send_request(input logic op, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr, output grant_type g);
      while (!gapless && $urandom_range(99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.operation     <= op;
      req_bus.request_size  <= size;
      req_bus.block_address <= addr;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      g = compute_grant(op, size, addr);
      pending_grants.push_back(g);
      if (op == OP_ALLOC && g.status == STATUS_OK)
         live_blocks.push_back(((g.address - model_base - HDR) / MIN_BLK) % GRANULES);
   endtask

   // stop sending and wait until every expected beat has come back
   task automatic finish_outstanding();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_heap_base(input logic [ADDR_W-1:0] base);
      csr_bus.valid     <= 1'b1;
      csr_bus.heap_base <= base;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      model_base = base;
      base_writes++;
   endtask

   // ---------------------------------------------------------------------------
   // result checker and sink-side stalls
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : check_grants
      grant_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_grants.size() == 0) begin
            $error("result beat with no request outstanding");
            fail_count++;
         end else begin
            want = pending_grants.pop_front();
            if (rsp_bus.result_address !== want.address) begin
               $error("result_address: expected %h, got %h", want.address,
                      rsp_bus.result_address);
               fail_count++;
            end
            if (rsp_bus.block_bytes !== want.bytes) begin
               $error("block_bytes: expected %0d, got %0d", want.bytes, rsp_bus.block_bytes);
               fail_count++;
            end
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               fail_count++;
            end
            if (want.status == STATUS_TOO_LARGE)
               large_count++;
            else if (want.status == STATUS_NO_MEMORY)
               full_count++;
            else if (want.op == OP_ALLOC)
               alloc_count++;
            else
               free_count++;
         end
      end
      rsp_bus.ready <= gapless || ($urandom_range(99) >= 14);
   end

   // ---------------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------------
   // class edges: empty request, exact fits, the largest class and past it
   task automatic test_size_classes();
      logic [SIZE_W-1:0] sizes [11];
      grant_type g;
      sizes = '{16'd0, 16'd4, 16'd5, 16'd12, 16'd13, 16'd60, 16'd1020, 16'd2044,
                16'(MAX_BLOCK - HDR), 16'(MAX_BLOCK - HDR + 1), 16'hFFFF};
      foreach (sizes[i]) send_request(OP_ALLOC, sizes[i], $urandom, g);
   endtask

   // freed blocks come back last-in first-out
   task automatic test_lifo_reuse();
      grant_type g;
      int        gran;
      finish_outstanding();
      write_heap_base(32'hFFFF_FFFF);
      repeat (3) send_request(OP_ALLOC, 16'd20, $urandom, g);
      repeat (2) begin
         gran = live_blocks.pop_back();
         send_request(OP_FREE, SIZE_W'($urandom), user_address(gran), g);
      end
      repeat (2) send_request(OP_ALLOC, 16'd20, $urandom, g);
   endtask

   // a double free puts the block on its list twice, no check is made
   task automatic test_double_free();
      grant_type g;
      int        gran;
      send_request(OP_ALLOC, 16'd5000, $urandom, g);
      gran = live_blocks.pop_back();
      repeat (2) send_request(OP_FREE, SIZE_W'($urandom), user_address(gran), g);
      repeat (2) send_request(OP_ALLOC, 16'd5000, $urandom, g);
   endtask

   // mostly small allocations, frees of live blocks in random order
   task automatic test_random_traffic(input int count, input logic [ADDR_W-1:0] base,
                                      input bit no_gaps);
      grant_type         g;
      int                pick;
      int                idx;
      int                gran;
      logic [SIZE_W-1:0] size;
      finish_outstanding();
      write_heap_base(base);
      gapless = no_gaps;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 45 && live_blocks.size() != 0) begin
            idx  = $urandom_range(live_blocks.size() - 1);
            gran = live_blocks[idx];
            live_blocks.delete(idx);
            send_request(OP_FREE, SIZE_W'($urandom), user_address(gran), g);
         end else begin
            pick = $urandom_range(99);
            if (pick < 60)
               size = SIZE_W'($urandom_range(60));
            else if (pick < 85)
               size = SIZE_W'($urandom_range(1000));
            else if (pick < 96)
               size = SIZE_W'($urandom_range(3000));
            else
               size = SIZE_W'($urandom);
            send_request(OP_ALLOC, size, $urandom, g);
         end
      end
      gapless = 1'b0;
   endtask

   // largest blocks until the bump pointer runs out, then reuse one of them
   task automatic test_heap_exhausted();
      grant_type g;
      int        tries;
      int        gran;
      tries = 0;
      do begin
         send_request(OP_ALLOC, 16'(MAX_BLOCK - HDR), $urandom, g);
         tries++;
      end while (g.status != STATUS_NO_MEMORY && tries < 40);
      gran = live_blocks.pop_back();
      send_request(OP_FREE, SIZE_W'($urandom), user_address(gran), g);
      send_request(OP_ALLOC, 16'(MAX_BLOCK - HDR), $urandom, g);
      send_request(OP_ALLOC, 16'(MAX_BLOCK - HDR), $urandom, g);
   endtask

   // ---------------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.operation     <= OP_ALLOC;
      req_bus.request_size  <= '0;
      req_bus.block_address <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.heap_base     <= '0;
      model_base = '0;
      bump_ptr   = '0;
      foreach (class_heads[i]) class_heads[i] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_heap_base('0);
      test_size_classes();
      test_lifo_reuse();
      test_double_free();
      test_random_traffic(440, $urandom, 1'b0);
      test_random_traffic(440, 32'h8000_0000, 1'b0);
      test_random_traffic(440, $urandom, 1'b1);
      test_random_traffic(440, 32'h0000_1000, 1'b0);
      test_heap_exhausted();
      test_random_traffic(120, $urandom, 1'b0);
      finish_outstanding();

      $display("checked %0d allocations, %0d frees, %0d oversize and %0d out-of-heap results",
               alloc_count, free_count, large_count, full_count);
      $display("across %0d heap base settings, with idle gaps on both channels",
               base_writes);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule
